// ===== rtl/sorted_key_table_defines.svh =====
// Assertion macros for the sorted key table.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside of reset.
`define SKT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SKT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKT_ASSERT(label, clk, rst_n, prop, msg)
`define SKT_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

// ===== rtl/skt_pkg.sv =====
package skt_pkg;

  localparam int SKT_CAPACITY = 32;
  localparam int CMD_W        = 2;
  localparam int KEY_W        = 32;
  localparam int TAG_W        = 64;
  localparam int KIND_W       = 3;

  // Command codes of a request
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_FIND = 2'd2
  } cmd_t;

  // Result codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY    = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_ADD_FAIL = 3'd2,
    KIND_DEL_FAIL = 3'd3,
    KIND_MISS     = 3'd4,
    KIND_HIT      = 3'd5
  } kind_t;

  // One table entry as held in memory
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // One result on its way out
  typedef struct packed {
    kind_t                   kind;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    last;
  } result_t;

endpackage

// ===== rtl/skt_in_if.sv =====
interface skt_in_if import skt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;
  logic [TAG_W-1:0]        tag;

  modport source (output valid, output cmd, output key, output tag, input ready);
  modport sink (input valid, input cmd, input key, input tag, output ready);
endinterface

// ===== rtl/skt_out_if.sv =====
interface skt_out_if import skt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [KEY_W-1:0] out_key;
  logic [TAG_W-1:0]        out_tag;
  logic                    last;

  modport source (output valid, output kind, output out_key, output out_tag, output last,
                  input ready);
  modport sink (input valid, input kind, input out_key, input out_tag, input last,
                output ready);
endinterface

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: entries live in one memory, sorted by signed key, one read per cycle.
// Each request runs a scan of the stored entries, then for a successful add or delete a
// shift of the entries above the slot and a listing of the whole table.
// One request at a time; listing streams one entry per cycle through a two-deep result
// queue while the queue has room.
// Reset (synchronous, rst_n low) empties the table and the result queue; memory is kept.
`include "sorted_key_table_defines.svh"

module sorted_key_table import skt_pkg::*; #(
  parameter int CAPACITY = SKT_CAPACITY
) (
  input logic       clk,
  input logic       rst_n,
  skt_in_if.sink    in_req,
  skt_out_if.source out_rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_LIST   = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r;
  logic signed [KEY_W-1:0] key_r;
  logic [TAG_W-1:0]        tag_r;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [CW-1:0]           ix_r, ix_nxt;
  logic [CW-1:0]           left_r, left_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic                    present_r, present_nxt;
  entry_t                  hit_r;

  entry_t                  mem [CAPACITY];
  entry_t                  rdata_r;
  logic                    pend_r;
  logic [AW-1:0]           pend_idx_r;
  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  entry_t                  wr_data;

  result_t                 q_r [2];
  logic                    wp_r, rp_r;
  logic [1:0]              cnt_r;
  logic                    push, pop;
  result_t                 push_data;
  logic [1:0]              occ;
  logic                    accept;

  assign accept = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign pop = out_rsp.valid && out_rsp.ready;
  assign occ = cnt_r - {1'b0, pop};

  // Sequence one request: scan, decide, shift, list
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    ix_nxt      = ix_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    present_nxt = present_r;
    rd_en       = 1'b0;
    rd_addr     = ix_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pend_idx_r;
    wr_data     = rdata_r;
    push        = 1'b0;
    push_data   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req.cmd) inside
            CMD_ADD, CMD_DEL, CMD_FIND: begin
              state_nxt   = ST_SCAN;
              ix_nxt      = '0;
              left_nxt    = fill_r;
              pos_nxt     = '0;
              present_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Count keys below the request key and look for an equal one
        if (left_r != '0) begin
          rd_en    = 1'b1;
          ix_nxt   = ix_r + 1'b1;
          left_nxt = left_r - 1'b1;
        end
        if (pend_r) begin
          if (rdata_r.key < key_r) pos_nxt = pos_r + 1'b1;
          if (rdata_r.key == key_r) present_nxt = 1'b1;
        end
        if (left_r == '0 && !pend_r) state_nxt = ST_DECIDE;
      end

      ST_DECIDE: begin
        unique case (cmd_r)
          CMD_ADD: begin
            if (present_r || fill_r == CAP_W) begin
              if (cnt_r != 2'd2) begin
                push           = 1'b1;
                push_data.kind = KIND_ADD_FAIL;
                push_data.last = 1'b1;
                state_nxt      = ST_IDLE;
              end
            end else begin
              state_nxt = ST_SHIFT;
              ix_nxt    = fill_r - 1'b1;
              left_nxt  = fill_r - pos_r;
            end
          end
          CMD_DEL: begin
            if (!present_r) begin
              if (cnt_r != 2'd2) begin
                push           = 1'b1;
                push_data.kind = KIND_DEL_FAIL;
                push_data.last = 1'b1;
                state_nxt      = ST_IDLE;
              end
            end else begin
              state_nxt = ST_SHIFT;
              ix_nxt    = pos_r + 1'b1;
              left_nxt  = fill_r - pos_r - 1'b1;
            end
          end
          CMD_FIND: begin
            if (cnt_r != 2'd2) begin
              push           = 1'b1;
              push_data.last = 1'b1;
              if (present_r) begin
                push_data.kind = KIND_HIT;
                push_data.key  = hit_r.key;
                push_data.tag  = hit_r.tag;
              end else begin
                push_data.kind = KIND_MISS;
              end
              state_nxt = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      ST_SHIFT: begin
        // Move entries one slot up (add) or down (delete), one per cycle
        if (left_r != '0) begin
          rd_en    = 1'b1;
          ix_nxt   = (cmd_r == CMD_ADD) ? ix_r - 1'b1 : ix_r + 1'b1;
          left_nxt = left_r - 1'b1;
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = (cmd_r == CMD_ADD) ? pend_idx_r + 1'b1 : pend_idx_r - 1'b1;
        end
        if (left_r == '0 && !pend_r) begin
          if (cmd_r == CMD_ADD) begin
            wr_en       = 1'b1;
            wr_addr     = pos_r[AW-1:0];
            wr_data.key = key_r;
            wr_data.tag = tag_r;
            fill_nxt    = fill_r + 1'b1;
          end else begin
            fill_nxt = fill_r - 1'b1;
          end
          state_nxt = ST_LIST;
          ix_nxt    = '0;
          left_nxt  = fill_nxt;
        end
      end

      ST_LIST: begin
        if (fill_r == '0) begin
          if (cnt_r != 2'd2) begin
            push           = 1'b1;
            push_data.kind = KIND_EMPTY;
            push_data.last = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          // Read ahead only as far as the result queue has room
          if (left_r != '0 && (occ + {1'b0, pend_r}) < 2'd2) begin
            rd_en    = 1'b1;
            ix_nxt   = ix_r + 1'b1;
            left_nxt = left_r - 1'b1;
          end
          if (pend_r) begin
            push           = 1'b1;
            push_data.kind = KIND_ENTRY;
            push_data.key  = rdata_r.key;
            push_data.tag  = rdata_r.tag;
            push_data.last = (CW'(pend_idx_r) == fill_r - 1'b1);
          end
          if (left_r == '0 && !pend_r) state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      ix_r      <= '0;
      left_r    <= '0;
      pos_r     <= '0;
      present_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      ix_r      <= ix_nxt;
      left_r    <= left_nxt;
      pos_r     <= pos_nxt;
      present_r <= present_nxt;
      pend_r    <= rd_en;
    end
  end

  // Hold the request and the matching entry
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_req.cmd);
      key_r <= in_req.key;
      tag_r <= in_req.tag;
    end
    if (state_r == ST_SCAN && pend_r && rdata_r.key == key_r) hit_r <= rdata_r;
    pend_idx_r <= rd_addr;
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Two-deep result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_r ^ push;
      rp_r  <= rp_r ^ pop;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end

  assign out_rsp.valid   = (cnt_r != 2'd0);
  assign out_rsp.kind    = q_r[rp_r].kind;
  assign out_rsp.out_key = q_r[rp_r].key;
  assign out_rsp.out_tag = q_r[rp_r].tag;
  assign out_rsp.last    = q_r[rp_r].last;

  // Checks
  `SKT_ASSERT(a_fill_bound, clk, rst_n, fill_r <= CAP_W, "table fill above capacity")
  `SKT_ASSERT(a_queue_room, clk, rst_n, push |-> (cnt_r != 2'd2 || pop), "queue overflow")
  `SKT_ASSERT(a_no_rw_clash, clk, rst_n, (wr_en && rd_en) |-> wr_addr != rd_addr, "rw clash")
  `SKT_ASSERT_RST(a_reset_empty, clk, !rst_n |=> (fill_r == '0 && cnt_r == 2'd0), "reset")

endmodule
